// ===== sv/coapf_pkg.sv =====
// Shared types, codes and constants for the CoAP message framer.
package coapf_pkg;

	// Command codes carried in s_tuser
	localparam logic [2:0] CMD_HEADER  = 3'd0;
	localparam logic [2:0] CMD_TOKEN   = 3'd1;
	localparam logic [2:0] CMD_OPT_HDR = 3'd2;
	localparam logic [2:0] CMD_OPT_VAL = 3'd3;
	localparam logic [2:0] CMD_PAYLOAD = 3'd4;
	localparam logic [2:0] CMD_END     = 3'd5;

	// Byte request kinds passed from the front to the back
	localparam logic [1:0] REQ_PUSH   = 2'd0;
	localparam logic [1:0] REQ_NOVAL  = 2'd1;
	localparam logic [1:0] REQ_REJECT = 2'd2;

	// Error / status codes
	localparam logic [1:0] ERR_OK    = 2'd0;
	localparam logic [1:0] ERR_TOKEN = 2'd1;
	localparam logic [1:0] ERR_SIZE  = 2'd2;

	// Protocol constants
	localparam int unsigned DEF_MAX_MESSAGE_BYTES = 1024;
	localparam logic [3:0]  MAX_TOKEN_BYTES       = 4'd8;
	localparam logic [15:0] EXT1_BASE             = 16'd13;
	localparam logic [15:0] EXT2_BASE             = 16'd269;
	localparam logic [3:0]  NIB_EXT1              = 4'd13;
	localparam logic [3:0]  NIB_EXT2              = 4'd14;
	localparam logic [7:0]  PAYLOAD_MARKER        = 8'hFF;
	localparam logic [1:0]  DEF_VERSION           = 2'd1;

	// Expansion and queue sizing
	localparam int unsigned MAX_REQS    = 5;
	localparam int unsigned QUEUE_DEPTH = 4;

	// One byte request
	typedef struct packed {
		logic [7:0] data;
		logic [1:0] kind;
		logic       clr;
		logic       last;
		logic       done;
	} coapf_req_t;

endpackage

// ===== sv/coapf_front.sv =====
// Front part: accepts commands, tracks option and payload state, expands into byte requests.
module coapf_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [1:0]            version,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [2:0]            command,
	input  logic [1:0]            msg_type,
	input  logic [7:0]            msg_code,
	input  logic [15:0]           message_id,
	input  logic [3:0]            token_length,
	input  logic [7:0]            data_byte,
	input  logic [15:0]           option_number,
	input  logic [15:0]           option_length,
	output logic                  req_valid,
	input  logic                  req_ready,
	output coapf_pkg::coapf_req_t req
);
	import coapf_pkg::*;

	logic        accept;
	logic        last_step;
	logic        push;

	// Front state
	logic [15:0] prev_opt_q;
	logic        pay_started_q;

	// Held, already expanded item
	logic        hold_valid_q;
	logic [7:0]  bytes_q [MAX_REQS];
	logic [2:0]  count_q;
	logic [2:0]  step_q;
	logic [1:0]  kind_q;
	logic        clr_q;
	logic        done_q;

	// Expansion of the incoming command
	logic [7:0]  bytes_d [MAX_REQS];
	logic [2:0]  count_d;
	logic [1:0]  kind_d;
	logic        clr_d;
	logic        done_d;
	logic [15:0] delta;
	logic [15:0] delta_x;
	logic [15:0] olen_x;
	logic [2:0]  k;

	function automatic logic [3:0] nibble(input logic [15:0] v);
		if (v < EXT1_BASE)
			return v[3:0];
		else if (v < EXT2_BASE)
			return NIB_EXT1;
		else
			return NIB_EXT2;
	endfunction

	assign delta   = option_number - prev_opt_q;
	assign delta_x = delta - EXT2_BASE;
	assign olen_x  = option_length - EXT2_BASE;

	// Build the byte list for the incoming command
	always_comb begin
		for (int i = 0; i < MAX_REQS; i++)
			bytes_d[i] = '0;
		count_d = 3'd1;
		kind_d  = REQ_PUSH;
		clr_d   = 1'b0;
		done_d  = 1'b0;
		k       = 3'd1;
		unique case (command) inside
			CMD_HEADER: begin
				clr_d = 1'b1;
				if (token_length > MAX_TOKEN_BYTES) begin
					kind_d = REQ_REJECT;
				end else begin
					bytes_d[0] = {version, msg_type, token_length};
					bytes_d[1] = msg_code;
					bytes_d[2] = message_id[15:8];
					bytes_d[3] = message_id[7:0];
					count_d    = 3'd4;
				end
			end
			CMD_TOKEN, CMD_OPT_VAL: begin
				bytes_d[0] = data_byte;
			end
			CMD_OPT_HDR: begin
				bytes_d[0] = {nibble(delta), nibble(option_length)};
				if (delta >= EXT2_BASE) begin
					bytes_d[k]        = delta_x[15:8];
					bytes_d[k + 3'd1] = delta_x[7:0];
					k = k + 3'd2;
				end else if (delta >= EXT1_BASE) begin
					bytes_d[k] = 8'(delta - EXT1_BASE);
					k = k + 3'd1;
				end
				if (option_length >= EXT2_BASE) begin
					bytes_d[k]        = olen_x[15:8];
					bytes_d[k + 3'd1] = olen_x[7:0];
					k = k + 3'd2;
				end else if (option_length >= EXT1_BASE) begin
					bytes_d[k] = 8'(option_length - EXT1_BASE);
					k = k + 3'd1;
				end
				count_d = k;
			end
			CMD_PAYLOAD: begin
				if (!pay_started_q) begin
					bytes_d[0] = PAYLOAD_MARKER;
					bytes_d[1] = data_byte;
					count_d    = 3'd2;
				end else begin
					bytes_d[0] = data_byte;
				end
			end
			CMD_END: begin
				kind_d = REQ_NOVAL;
				done_d = 1'b1;
			end
			default: begin
				kind_d = REQ_NOVAL;
			end
		endcase
	end

	// Handshakes
	assign last_step = (step_q == count_q - 3'd1);
	assign push      = hold_valid_q && req_ready;
	assign in_ready  = !hold_valid_q || (req_ready && last_step);
	assign accept    = in_valid && in_ready;

	// Request presented to the queue
	assign req_valid = hold_valid_q;
	always_comb begin
		req.data = bytes_q[step_q];
		req.kind = kind_q;
		req.clr  = clr_q && (step_q == 3'd0);
		req.last = last_step;
		req.done = done_q;
	end

	// Control state: hold valid, step counter, option and payload tracking
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_valid_q  <= 1'b0;
			step_q        <= '0;
			prev_opt_q    <= '0;
			pay_started_q <= 1'b0;
		end else begin
			if (accept) begin
				hold_valid_q <= 1'b1;
				step_q       <= '0;
				case (command)
					CMD_HEADER: begin
						prev_opt_q    <= '0;
						pay_started_q <= 1'b0;
					end
					CMD_OPT_HDR: prev_opt_q    <= option_number;
					CMD_PAYLOAD: pay_started_q <= 1'b1;
					default: ;
				endcase
			end else if (push) begin
				if (last_step)
					hold_valid_q <= 1'b0;
				else
					step_q <= step_q + 3'd1;
			end
		end
	end

	// Payload of the held item
	always_ff @(posedge clk) begin
		if (accept) begin
			bytes_q <= bytes_d;
			count_q <= count_d;
			kind_q  <= kind_d;
			clr_q   <= clr_d;
			done_q  <= done_d;
		end
	end

endmodule

// ===== sv/coapf_queue.sv =====
// Short request queue between the front and the back.
module coapf_queue (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  wr_valid,
	output logic                  wr_ready,
	input  coapf_pkg::coapf_req_t wr_req,
	output logic                  rd_valid,
	input  logic                  rd_ready,
	output coapf_pkg::coapf_req_t rd_req
);
	import coapf_pkg::*;

	localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
	localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

	coapf_req_t        mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  fill_q;
	logic              do_wr;
	logic              do_rd;

	assign wr_ready = (fill_q != CNT_W'(QUEUE_DEPTH));
	assign rd_valid = (fill_q != '0);
	assign rd_req   = mem_q[rd_ptr_q];
	assign do_wr    = wr_valid && wr_ready;
	assign do_rd    = rd_valid && rd_ready;

	// Advance pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (do_wr)
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			if (do_rd)
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			if (do_wr && !do_rd)
				fill_q <= fill_q + CNT_W'(1);
			else if (do_rd && !do_wr)
				fill_q <= fill_q - CNT_W'(1);
		end
	end

	// Store entries
	always_ff @(posedge clk) begin
		if (do_wr)
			mem_q[wr_ptr_q] <= wr_req;
	end

endmodule

// ===== sv/coapf_back.sv =====
// Back part: applies token and size checks, counts bytes, holds the output result.
module coapf_back #(
	parameter int unsigned MAX_MESSAGE_BYTES = coapf_pkg::DEF_MAX_MESSAGE_BYTES
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  req_valid,
	output logic                  req_ready,
	input  coapf_pkg::coapf_req_t req,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [7:0]            out_byte,
	output logic                  byte_valid,
	output logic                  last_of_item,
	output logic                  done_res,
	output logic [1:0]            status
);
	import coapf_pkg::*;

	localparam int unsigned CNT_W = $clog2(MAX_MESSAGE_BYTES + 1);

	logic [CNT_W-1:0] count_q;
	logic [1:0]       err_q;
	logic             out_valid_q;
	logic [7:0]       byte_q;
	logic             bvalid_q;
	logic             last_q;
	logic             done_q;
	logic [1:0]       status_q;

	logic             take;
	logic [CNT_W-1:0] cnt_in;
	logic [1:0]       err_in;
	logic [CNT_W-1:0] cnt_d;
	logic [1:0]       err_d;
	logic [7:0]       byte_d;
	logic             bvalid_d;

	assign req_ready = !out_valid_q || out_ready;
	assign take      = req_valid && req_ready;

	// Evaluate one request against message state
	always_comb begin
		cnt_in   = (req.clr || req.kind == REQ_REJECT) ? '0 : count_q;
		err_in   = (req.clr || req.kind == REQ_REJECT) ? ERR_OK : err_q;
		cnt_d    = cnt_in;
		err_d    = err_in;
		byte_d   = '0;
		bvalid_d = 1'b0;
		unique case (req.kind)
			REQ_PUSH: begin
				if (err_in == ERR_TOKEN) begin
					err_d = err_in;
				end else if (cnt_in >= CNT_W'(MAX_MESSAGE_BYTES)) begin
					err_d = ERR_SIZE;
				end else begin
					cnt_d    = cnt_in + CNT_W'(1);
					byte_d   = req.data;
					bvalid_d = 1'b1;
				end
			end
			REQ_REJECT: err_d = ERR_TOKEN;
			REQ_NOVAL:  err_d = err_in;
			default:    err_d = err_in;
		endcase
	end

	// Update message state and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			err_q       <= ERR_OK;
			out_valid_q <= 1'b0;
		end else begin
			if (take) begin
				count_q     <= cnt_d;
				err_q       <= err_d;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Hold the result
	always_ff @(posedge clk) begin
		if (take) begin
			byte_q   <= byte_d;
			bvalid_q <= bvalid_d;
			last_q   <= req.last;
			done_q   <= req.done;
			status_q <= err_d;
		end
	end

	assign out_valid    = out_valid_q;
	assign out_byte     = byte_q;
	assign byte_valid   = bvalid_q;
	assign last_of_item = last_q;
	assign done_res     = done_q;
	assign status       = status_q;

endmodule

// ===== sv/coap_message_framer.sv =====
// Top level of the CoAP message framer: stream ports, register port, front, queue and back.
//
//  Channel | Direction | Handshake        | Content
//  s_*     | in        | s_tvalid/tready  | one command with header, option and data fields
//  m_*     | out       | m_tvalid/tready  | one serialized byte or status result
//  APB     | in        | psel/penable     | protocol_version at address 0
//
// Single-byte commands sustain one per cycle while the queue accepts; a command producing N
// results (header 4, option header up to 5, first payload 2) holds the front until all are sent.
// Unless stalled, the front emits one request per cycle into a four-entry queue and the back
// retires one per cycle; its result reaches m_tdata in the cycle after it leaves the queue.
// arst_n clears front, queue and back control state and sets the version to 1.
// A stalled m_tready fills the queue, then holds the front and s_tready.
module coap_message_framer #(
	parameter int unsigned MAX_MESSAGE_BYTES = coapf_pkg::DEF_MAX_MESSAGE_BYTES
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// msg_type[1:0], msg_code[9:2], message_id[25:10], token_length[29:26],
	// data_byte[37:30], option_number[53:38], option_length[69:54], zero [71:70]
	input  logic [71:0] s_tdata,
	// command[2:0]
	input  logic [2:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// out_byte[7:0]
	output logic [7:0]  m_tdata,
	// byte_valid[0], done_res[1], status[3:2]
	output logic [3:0]  m_tuser,
	output logic        m_tlast,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import coapf_pkg::*;

	logic [1:0]  version_q;
	logic        cfg_wr;
	coapf_req_t  f_req;
	coapf_req_t  b_req;
	logic        f_valid;
	logic        f_ready;
	logic        b_valid;
	logic        b_ready;
	logic [7:0]  out_byte;
	logic        byte_valid;
	logic        done_res;
	logic [1:0]  status;

	// Register port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == 1'b0);
	assign prdata = (paddr[2] == 1'b0) ? {30'd0, version_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			version_q <= DEF_VERSION;
		else if (cfg_wr)
			version_q <= pwdata[1:0];
	end

	coapf_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.version       (version_q),
		.in_valid      (s_tvalid),
		.in_ready      (s_tready),
		.command       (s_tuser),
		.msg_type      (s_tdata[1:0]),
		.msg_code      (s_tdata[9:2]),
		.message_id    (s_tdata[25:10]),
		.token_length  (s_tdata[29:26]),
		.data_byte     (s_tdata[37:30]),
		.option_number (s_tdata[53:38]),
		.option_length (s_tdata[69:54]),
		.req_valid     (f_valid),
		.req_ready     (f_ready),
		.req           (f_req)
	);

	coapf_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (f_valid),
		.wr_ready (f_ready),
		.wr_req   (f_req),
		.rd_valid (b_valid),
		.rd_ready (b_ready),
		.rd_req   (b_req)
	);

	coapf_back #(
		.MAX_MESSAGE_BYTES (MAX_MESSAGE_BYTES)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.req_valid    (b_valid),
		.req_ready    (b_ready),
		.req          (b_req),
		.out_valid    (m_tvalid),
		.out_ready    (m_tready),
		.out_byte     (out_byte),
		.byte_valid   (byte_valid),
		.last_of_item (m_tlast),
		.done_res     (done_res),
		.status       (status)
	);

	assign m_tdata = out_byte;
	assign m_tuser = {status, done_res, byte_valid};

endmodule

// ===== sv/coapf_checker.sv =====
// Port-level checker for the CoAP message framer, bound to the top level.
module coapf_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [7:0]  m_tdata,
	input logic [3:0]  m_tuser,
	input logic        m_tlast
);

	// Hold a stalled result
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
			&& $stable(m_tlast))
		else $error("stalled result changed");

	// A suppressed byte reads as zero
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[0] |-> m_tdata == 8'd0)
		else $error("suppressed byte not zero");

	// End result is the last of its request and carries no byte
	a_done: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[1] |-> m_tlast && !m_tuser[0])
		else $error("end result malformed");

	// No byte leaves while the token error stands, and no undefined status
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tuser[3:2] != 2'd3 && !(m_tuser[0] && m_tuser[3:2] == 2'd1))
		else $error("bad status");

endmodule

bind coap_message_framer coapf_checker u_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);

// ===== bench/coapf_frame_checker.sv =====
// Checker for the CoAP message framer: predicts every serialized byte and compares results.
`timescale 1ns / 100ps
module coapf_frame_checker #(
	parameter logic [2:0] VERSION_ADDR = 3'd0
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	input  logic               s_tready,
	input  logic [71:0]        s_tdata,
	input  logic [2:0]         s_tuser,
	input  logic               m_tvalid,
	input  logic               m_tready,
	input  logic [7:0]         m_tdata,
	input  logic [3:0]         m_tuser,
	input  logic               m_tlast,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [2:0]         paddr,
	input  logic [31:0]        pwdata,
	input  logic               pready,
	output int unsigned        fail_count,
	output int unsigned        expected_left
);
	import coapf_pkg::*;

	localparam int unsigned MAX_BYTES   = DEF_MAX_MESSAGE_BYTES;
	localparam int unsigned MAX_PRINTED = 40;

	// One predicted output result
	typedef struct packed {
		logic [7:0] out_byte;
		logic       byte_valid;
		logic       last_of_item;
		logic       done_res;
		logic [1:0] status;
	} framed_byte_t;

	// Predicted framer state
	logic [1:0]   version;
	logic [15:0]  prev_opt;
	logic         payload_on;
	int unsigned  msg_bytes;
	logic [1:0]   err;

	framed_byte_t expected_bytes[$];
	framed_byte_t held;
	bit           have_held;
	framed_byte_t want;

	initial begin
		fail_count    = 0;
		expected_left = 0;
		have_held     = 1'b0;
	end

	task automatic report(input string what, input logic [15:0] got, input logic [15:0] exp_v);
		if (fail_count < MAX_PRINTED)
			$display("%0t ns  %s: got %0h, want %0h", $time, what, got, exp_v);
		fail_count++;
	endtask

	// Hold one result back so the final one of a request can be marked
	task automatic emit(input logic [7:0] b, input logic valid);
		if (have_held)
			expected_bytes.push_back(held);
		held.out_byte     = valid ? b : 8'h00;
		held.byte_valid   = valid;
		held.last_of_item = 1'b0;
		held.done_res     = 1'b0;
		held.status       = err;
		have_held         = 1'b1;
	endtask

	// Count a message byte, or drop it on a rejected or full message
	task automatic push_byte(input logic [7:0] b);
		if (err == ERR_TOKEN) begin
			emit(8'h00, 1'b0);
		end else if (msg_bytes >= MAX_BYTES) begin
			err = ERR_SIZE;
			emit(8'h00, 1'b0);
		end else begin
			msg_bytes++;
			emit(b, 1'b1);
		end
	endtask

	function automatic logic [3:0] nibble_of(input logic [15:0] v);
		if (v < EXT1_BASE)
			return v[3:0];
		if (v < EXT2_BASE)
			return NIB_EXT1;
		return NIB_EXT2;
	endfunction

	// Extended delta or length bytes after the nibble byte
	task automatic push_extended(input logic [15:0] v);
		logic [15:0] rest;
		if (v >= EXT2_BASE) begin
			rest = v - EXT2_BASE;
			push_byte(rest[15:8]);
			push_byte(rest[7:0]);
		end else if (v >= EXT1_BASE) begin
			rest = v - EXT1_BASE;
			push_byte(rest[7:0]);
		end
	endtask

	// Expand one accepted request into its expected results
	task automatic frame_command(input logic [2:0] cmd, input logic [71:0] word);
		logic [1:0]  mtype;
		logic [7:0]  code;
		logic [15:0] mid;
		logic [3:0]  tlen;
		logic [7:0]  data;
		logic [15:0] onum;
		logic [15:0] olen;
		logic [15:0] delta;
		mtype = word[1:0];
		code  = word[9:2];
		mid   = word[25:10];
		tlen  = word[29:26];
		data  = word[37:30];
		onum  = word[53:38];
		olen  = word[69:54];
		case (cmd) inside
			CMD_HEADER: begin
				prev_opt   = 16'd0;
				payload_on = 1'b0;
				msg_bytes  = 0;
				err        = ERR_OK;
				if (tlen > MAX_TOKEN_BYTES) begin
					err = ERR_TOKEN;
					emit(8'h00, 1'b0);
				end else begin
					push_byte({version, mtype, tlen});
					push_byte(code);
					push_byte(mid[15:8]);
					push_byte(mid[7:0]);
				end
			end
			CMD_TOKEN, CMD_OPT_VAL: begin
				push_byte(data);
			end
			CMD_OPT_HDR: begin
				delta    = onum - prev_opt;
				prev_opt = onum;
				push_byte({nibble_of(delta), nibble_of(olen)});
				push_extended(delta);
				push_extended(olen);
			end
			CMD_PAYLOAD: begin
				if (!payload_on) begin
					payload_on = 1'b1;
					push_byte(PAYLOAD_MARKER);
				end
				push_byte(data);
			end
			default: begin
				emit(8'h00, 1'b0);
			end
		endcase
		held.last_of_item = 1'b1;
		held.done_res     = (cmd == CMD_END);
		expected_bytes.push_back(held);
		have_held = 1'b0;
	endtask

	// Compare results, then predict new requests and track register writes
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			version    = DEF_VERSION;
			prev_opt   = 16'd0;
			payload_on = 1'b0;
			msg_bytes  = 0;
			err        = ERR_OK;
			have_held  = 1'b0;
			expected_bytes.delete();
			expected_left = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (expected_bytes.size() == 0) begin
					report("result with nothing expected", {3'b000, m_tuser, m_tlast, m_tdata},
						16'h0000);
				end else begin
					want = expected_bytes.pop_front();
					if (m_tdata !== want.out_byte)
						report("out_byte", 16'(m_tdata), 16'(want.out_byte));
					if (m_tuser[0] !== want.byte_valid)
						report("byte_valid", 16'(m_tuser[0]), 16'(want.byte_valid));
					if (m_tlast !== want.last_of_item)
						report("last_of_item", 16'(m_tlast), 16'(want.last_of_item));
					if (m_tuser[1] !== want.done_res)
						report("done_res", 16'(m_tuser[1]), 16'(want.done_res));
					if (m_tuser[3:2] !== want.status)
						report("status", 16'(m_tuser[3:2]), 16'(want.status));
				end
			end
			if (s_tvalid && s_tready)
				frame_command(s_tuser, s_tdata);
			if (psel && penable && pwrite && pready && paddr[2] == VERSION_ADDR[2])
				version = pwdata[1:0];
			expected_left = expected_bytes.size();
		end
	end

endmodule

// ===== bench/tb.sv =====
// Testbench top for the CoAP message framer: clock, reset, stimulus, pacing and verdict.
`timescale 1ns / 100ps
module tb;
	import coapf_pkg::*;

	localparam logic [2:0]  VERSION_ADDR     = 3'd0;
	localparam logic [2:0]  CMD_RSVD_A       = 3'd6;
	localparam logic [2:0]  CMD_RSVD_B       = 3'd7;
	localparam int unsigned DRAIN_CYCLES     = 20;
	localparam int unsigned WATCHDOG_LIMIT   = 4000;
	localparam int unsigned HOLDOFF_CYCLES   = 400;
	localparam int unsigned OVERSIZE_OPTIONS = 210;
	localparam int unsigned ITEMS_PER_PHASE  = 8;

	// Request fields, last member in the lowest bits
	typedef struct packed {
		logic [1:0]  pad;
		logic [15:0] option_length;
		logic [15:0] option_number;
		logic [7:0]  data_byte;
		logic [3:0]  token_length;
		logic [15:0] message_id;
		logic [7:0]  msg_code;
		logic [1:0]  msg_type;
	} cmd_fields_t;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [71:0] s_tdata  = '0;
	logic [2:0]  s_tuser  = CMD_HEADER;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [7:0]  m_tdata;
	logic [3:0]  m_tuser;
	logic        m_tlast;
	logic        psel     = 1'b0;
	logic        penable  = 1'b0;
	logic        pwrite   = 1'b0;
	logic [2:0]  paddr    = VERSION_ADDR;
	logic [31:0] pwdata   = '0;
	logic [31:0] prdata;
	logic        pready;

	int unsigned fail_count;
	int unsigned expected_left;
	int unsigned send_idle_pct  = 0;
	int unsigned recv_stall_pct = 0;
	int unsigned items_sent     = 0;
	int unsigned quiet_cycles   = 0;
	int unsigned holdoff_left   = 0;
	int unsigned target;
	bit          holdoff_req    = 1'b0;
	cmd_fields_t f;
	logic [15:0] onum;
	logic [1:0]  ver;

	coap_message_framer i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	coapf_frame_checker #(
		.VERSION_ADDR (VERSION_ADDR)
	) i_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_tvalid      (s_tvalid),
		.s_tready      (s_tready),
		.s_tdata       (s_tdata),
		.s_tuser       (s_tuser),
		.m_tvalid      (m_tvalid),
		.m_tready      (m_tready),
		.m_tdata       (m_tdata),
		.m_tuser       (m_tuser),
		.m_tlast       (m_tlast),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.pready        (pready),
		.fail_count    (fail_count),
		.expected_left (expected_left)
	);

	// 10 ns clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Receiver: random stalls, plus a long hold-off on request
	always @(negedge clk) begin
		if (holdoff_req) begin
			holdoff_req  = 1'b0;
			holdoff_left = HOLDOFF_CYCLES;
		end
		if (holdoff_left != 0) begin
			holdoff_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
		end
	end

	// Watchdog: end the run after too long without any transfer
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable && pready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	function automatic cmd_fields_t rand_fields();
		cmd_fields_t r;
		r.pad           = 2'b00;
		r.option_length = 16'($urandom);
		r.option_number = 16'($urandom);
		r.data_byte     = 8'($urandom);
		r.token_length  = 4'($urandom);
		r.message_id    = 16'($urandom);
		r.msg_code      = 8'($urandom);
		r.msg_type      = 2'($urandom);
		return r;
	endfunction

	// Offer one request and hold it until accepted; valid stays high into the next one
	task automatic send_cmd(input logic [2:0] cmd, input cmd_fields_t fl);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= fl;
		s_tuser  <= cmd;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		@(negedge clk);
		items_sent++;
	endtask

	task automatic send_header(input logic [1:0] mtype, input logic [7:0] code,
			input logic [15:0] mid, input logic [3:0] tlen);
		cmd_fields_t fl;
		fl              = rand_fields();
		fl.msg_type     = mtype;
		fl.msg_code     = code;
		fl.message_id   = mid;
		fl.token_length = tlen;
		send_cmd(CMD_HEADER, fl);
	endtask

	task automatic send_data(input logic [2:0] cmd, input logic [7:0] b);
		cmd_fields_t fl;
		fl           = rand_fields();
		fl.data_byte = b;
		send_cmd(cmd, fl);
	endtask

	task automatic send_option(input logic [15:0] num, input logic [15:0] len);
		cmd_fields_t fl;
		fl               = rand_fields();
		fl.option_number = num;
		fl.option_length = len;
		send_cmd(CMD_OPT_HDR, fl);
	endtask

	// Now and then slip in an arbitrary request, reserved codes included
	task automatic maybe_noise();
		logic [2:0] c;
		if ($urandom_range(0, 19) == 0) begin
			c = 3'($urandom_range(0, 7));
			send_cmd(c, rand_fields());
		end
	endtask

	// One mostly well-formed message with random content
	task automatic send_message();
		logic [3:0]  tlen;
		logic [15:0] num;
		logic [15:0] len;
		int unsigned n_tok;
		int unsigned n_val;
		tlen = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(9, 15))
			: 4'($urandom_range(0, 8));
		send_header(2'($urandom), 8'($urandom), 16'($urandom), tlen);
		n_tok = (tlen > MAX_TOKEN_BYTES) ? $urandom_range(0, 2) : tlen;
		repeat (n_tok) begin
			send_data(CMD_TOKEN, 8'($urandom));
			maybe_noise();
		end
		num = 16'd0;
		repeat ($urandom_range(0, 4)) begin
			case ($urandom_range(0, 3))
				0: num = num + 16'($urandom_range(0, 12));
				1: num = num + 16'($urandom_range(13, 268));
				2: num = num + 16'($urandom_range(269, 4000));
				default: num = 16'($urandom);
			endcase
			case ($urandom_range(0, 3)) inside
				0, 1: len = 16'($urandom_range(0, 12));
				2: len = 16'($urandom_range(13, 24));
				default: len = 16'($urandom);
			endcase
			send_option(num, len);
			n_val = (len > 24) ? $urandom_range(0, 2) : len;
			repeat (n_val)
				send_data(CMD_OPT_VAL, 8'($urandom));
			maybe_noise();
		end
		if ($urandom_range(0, 3) != 0) begin
			repeat ($urandom_range(1, 6))
				send_data(CMD_PAYLOAD, 8'($urandom));
		end
		maybe_noise();
		if ($urandom_range(0, 9) != 0)
			send_cmd(CMD_END, rand_fields());
	endtask

	// Drop valid and wait until every expected result is back
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (expected_left != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES)
			@(negedge clk);
	endtask

	// Register write: setup cycle, then access until pready
	task automatic write_version(input logic [1:0] v);
		logic [31:0] w;
		w       = $urandom;
		w[1:0]  = v;
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= VERSION_ADDR;
		pwdata  <= w;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	initial begin
		repeat (12)
			@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed: bytes before any header, field extremes, nibble boundaries
		send_data(CMD_PAYLOAD, 8'h00);
		send_data(CMD_TOKEN, 8'hFF);
		send_header(2'd3, 8'hFF, 16'hFFFF, 4'd8);
		send_data(CMD_TOKEN, 8'h00);
		send_data(CMD_TOKEN, 8'h5A);
		send_option(16'd0, 16'd0);
		send_option(16'd12, 16'd12);
		send_option(16'd25, 16'd13);
		send_option(16'd293, 16'd268);
		send_option(16'd562, 16'd269);
		send_option(16'hFFFF, 16'hFFFF);
		// decreasing number: delta wraps around
		send_option(16'd5, 16'd1);
		send_data(CMD_OPT_VAL, 8'hAA);
		send_data(CMD_PAYLOAD, 8'hFF);
		send_data(CMD_PAYLOAD, 8'h00);
		send_cmd(CMD_END, rand_fields());
		send_cmd(CMD_RSVD_A, rand_fields());
		send_cmd(CMD_RSVD_B, rand_fields());
		// token too long: everything up to the next header is dropped
		send_header(2'd0, 8'h00, 16'h0000, 4'd9);
		send_data(CMD_TOKEN, 8'h11);
		send_data(CMD_PAYLOAD, 8'h22);
		send_option(16'd300, 16'd400);
		send_cmd(CMD_END, rand_fields());
		send_header(2'd1, 8'h45, 16'h1234, 4'd15);
		send_header(2'd2, 8'h01, 16'h8001, 4'd0);
		send_cmd(CMD_END, rand_fields());
		wait_drained();

		// Random phases, each with its own pacing and version
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin
					send_idle_pct  = 0;
					recv_stall_pct = 0;
					ver            = 2'd3;
				end
				1: begin
					send_idle_pct  = 77;
					recv_stall_pct = 0;
					ver            = 2'd0;
				end
				2: begin
					send_idle_pct  = 0;
					recv_stall_pct = 77;
					ver            = 2'd2;
				end
				default: begin
					send_idle_pct  = 36;
					recv_stall_pct = 36;
					ver            = 2'($urandom);
				end
			endcase
			write_version(ver);
			@(negedge clk);
			if (phase == 0)
				holdoff_req = 1'b1;
			if (phase == 1) begin
				// Run one message past the size limit
				send_header(2'($urandom), 8'($urandom), 16'($urandom),
					4'($urandom_range(0, 8)));
				onum = 16'd0;
				repeat (OVERSIZE_OPTIONS) begin
					onum = onum + 16'($urandom_range(269, 300));
					send_option(onum, 16'($urandom_range(269, 65535)));
				end
				send_data(CMD_TOKEN, 8'($urandom));
				send_data(CMD_PAYLOAD, 8'($urandom));
				send_data(CMD_OPT_VAL, 8'($urandom));
				send_cmd(CMD_END, rand_fields());
			end
			target = items_sent + ITEMS_PER_PHASE;
			while (items_sent < target)
				send_message();
			wait_drained();
		end

		if (fail_count == 0 && expected_left == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
